[design/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg
// Shared widths, limits and command codes for the strongly connected
// components block.
// ----------------------------------------------------------------------------
package scc_pkg;

    localparam int VW             = 8;       // vertex id width
    localparam int CW             = 9;       // vertex count / class count width
    localparam int MAX_VERTICES   = 256;
    localparam int SCC_MAX_EDGES  = 1024;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // per-vertex walk record: class assigned flag and least stack position
    typedef struct packed {
        logic          done;
        logic [CW-1:0] low;
    } t_vinfo;

endpackage

[design/scc_if.sv]
// ----------------------------------------------------------------------------
// scc_if
// Valid/ready channels: command stream in, result stream out.
// ----------------------------------------------------------------------------
interface scc_in_if
    import scc_pkg::*;
();
    logic          valid;
    logic          ready;
    logic [1:0]    command;
    logic [VW-1:0] source_vertex;
    logic [VW-1:0] target_vertex;

    modport source (output valid, command, source_vertex, target_vertex, input ready);
    modport sink   (input valid, command, source_vertex, target_vertex, output ready);
endinterface

interface scc_out_if
    import scc_pkg::*;
();
    logic          valid;
    logic          ready;
    logic [VW-1:0] class_index;
    logic [CW-1:0] class_total;
    logic          error;

    modport source (output valid, class_index, class_total, error, input ready);
    modport sink   (input valid, class_index, class_total, error, output ready);
endinterface

[design/strongly_connected_components.sv]
// Sequence: an add answers straight from idle, a query first reads the class
//   memory in S_QRY, and a run starts with a clearing pass over the active
//   vertices before the walk and the sweeps.
// Throughput: one transaction at a time; the sequencer does one memory
//   access per port per cycle.
// Reset (synchronous, active low) empties the edge store, zeroes the class
//   count and sets vertex_count to 1; memories are not cleared.
// ----------------------------------------------------------------------------
// strongly_connected_components
// Edge store plus a memory-based sequencer doing a depth-first walk with
// least-position tracking and breadth-first class sweeps.
// ----------------------------------------------------------------------------
module strongly_connected_components
    import scc_pkg::*;
#(
    parameter int MAX_EDGES = SCC_MAX_EDGES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [CW-1:0] i_cfg_wr_data,
    scc_in_if.sink        i_in,
    scc_out_if.source     o_out
);

    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam logic [CW-1:0] VCAP = CW'(MAX_VERTICES);

    typedef struct packed {
        logic [VW-1:0]  vtx;
        logic [ECW-1:0] cur;
    } t_frame;

    typedef enum logic [4:0] {
        S_IDLE, S_QRY, S_INIT, S_ROOT, S_ROOT2, S_EDGE, S_TGT, S_DEC, S_POP,
        S_RESUME0, S_RES1, S_RES2, S_SW_HEAD, S_SW_Q, S_SW_A, S_SW_E, S_SW_T,
        S_SW_D
    } t_state;

    // memories
    logic [VW-1:0]  edge_mem [MAX_EDGES];
    logic [ECW-1:0] beg_mem  [MAX_VERTICES];
    logic [ECW-1:0] end_mem  [MAX_VERTICES];
    t_vinfo         vinfo_mem[MAX_VERTICES];
    logic [VW-1:0]  cls_mem  [MAX_VERTICES];
    t_frame         stk_mem  [MAX_VERTICES];
    logic [VW-1:0]  q_mem    [MAX_VERTICES];

    logic [VW-1:0]  r_edge_rd;
    logic [ECW-1:0] r_beg_rd, r_end_rd;
    logic           r_vld_rd;
    t_vinfo         r_vinfo_rd;
    logic [VW-1:0]  r_cls_rd;
    t_frame         r_stk_rd;
    logic [VW-1:0]  r_q_rd;

    // memory ports
    logic           edge_we;
    logic [EAW-1:0] edge_wa, edge_ra;
    logic [VW-1:0]  edge_wd;
    logic           beg_we, end_we;
    logic [VW-1:0]  adj_wa, adj_ra;
    logic [ECW-1:0] beg_wd, end_wd;
    logic           vinfo_we;
    logic [VW-1:0]  vinfo_wa, vinfo_ra;
    t_vinfo         vinfo_wd;
    logic           cls_we;
    logic [VW-1:0]  cls_wa, cls_ra, cls_wd;
    logic           stk_we;
    logic [VW-1:0]  stk_wa, stk_ra;
    t_frame         stk_wd;
    logic           q_we;
    logic [VW-1:0]  q_wa, q_ra, q_wd;

    // registers
    t_state            r_state, n_state;
    logic [CW-1:0]     r_vcount;
    logic [ECW-1:0]    r_total, n_total;
    logic [VW-1:0]     r_last_src, n_last_src;
    logic              r_any, n_any;
    logic [MAX_VERTICES-1:0] r_adj_vld, n_adj_vld;
    logic [CW-1:0]     r_cls_cnt, n_cls_cnt;
    logic [CW-1:0]     r_x, n_x;
    logic [VW-1:0]     r_y, n_y;
    logic              r_y_done, n_y_done;
    logic [VW-1:0]     r_z, n_z;
    logic [CW-1:0]     r_t, n_t;
    logic [CW-1:0]     r_low_y, n_low_y;
    logic [ECW-1:0]    r_cur, n_cur;
    logic [ECW-1:0]    r_end, n_end;
    logic [CW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_tail, n_tail;
    logic              r_prop, n_prop;
    logic              r_qok, n_qok;
    logic              r_out_valid, n_out_valid;
    logic [VW-1:0]     r_out_idx, n_out_idx;
    logic [CW-1:0]     r_out_tot, n_out_tot;
    logic              r_out_err, n_out_err;

    logic [CW-1:0] vn;
    logic          out_free, in_acc, add_err;

    always_comb begin
        if (r_vcount == '0) begin
            vn = CW'(1);
        end else if (r_vcount > VCAP) begin
            vn = VCAP;
        end else begin
            vn = r_vcount;
        end
    end

    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && out_free;
    assign in_acc      = i_in.valid && i_in.ready;
    assign add_err     = ({1'b0, i_in.source_vertex} >= vn)
                      || (r_total >= ECW'(MAX_EDGES))
                      || (r_any && (i_in.source_vertex < r_last_src));

    assign o_out.valid       = r_out_valid;
    assign o_out.class_index = r_out_idx;
    assign o_out.class_total = r_out_tot;
    assign o_out.error       = r_out_err;

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_last_src  = r_last_src;
        n_any       = r_any;
        n_adj_vld   = r_adj_vld;
        n_cls_cnt   = r_cls_cnt;
        n_x         = r_x;
        n_y         = r_y;
        n_y_done    = r_y_done;
        n_z         = r_z;
        n_t         = r_t;
        n_low_y     = r_low_y;
        n_cur       = r_cur;
        n_end       = r_end;
        n_head      = r_head;
        n_tail      = r_tail;
        n_prop      = r_prop;
        n_qok       = r_qok;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_idx   = r_out_idx;
        n_out_tot   = r_out_tot;
        n_out_err   = r_out_err;

        edge_we  = 1'b0;
        edge_wa  = r_total[EAW-1:0];
        edge_wd  = i_in.target_vertex;
        edge_ra  = r_cur[EAW-1:0];
        beg_we   = 1'b0;
        end_we   = 1'b0;
        adj_wa   = i_in.source_vertex;
        beg_wd   = r_total;
        end_wd   = r_total + ECW'(1);
        adj_ra   = r_x[VW-1:0];
        vinfo_we = 1'b0;
        vinfo_wa = r_x[VW-1:0];
        vinfo_wd = '{done: 1'b0, low: vn};
        vinfo_ra = r_x[VW-1:0];
        cls_we   = 1'b0;
        cls_wa   = r_z;
        cls_wd   = r_cls_cnt[VW-1:0];
        cls_ra   = i_in.target_vertex;
        stk_we   = 1'b0;
        stk_wa   = VW'(r_t - CW'(1));
        stk_wd   = '{vtx: r_y, cur: r_cur};
        stk_ra   = VW'(r_t - CW'(1));
        q_we     = 1'b0;
        q_wa     = r_tail[VW-1:0];
        q_wd     = r_z;
        q_ra     = r_head[VW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in.command)
                        CMD_ADD: begin
                            if (!add_err) begin
                                edge_we = 1'b1;
                                beg_we  = !r_adj_vld[i_in.source_vertex];
                                end_we  = 1'b1;
                                n_adj_vld[i_in.source_vertex] = 1'b1;
                                n_total    = r_total + ECW'(1);
                                n_last_src = i_in.source_vertex;
                                n_any      = 1'b1;
                            end
                            n_out_valid = 1'b1;
                            n_out_idx   = '0;
                            n_out_tot   = r_cls_cnt;
                            n_out_err   = add_err;
                        end
                        CMD_RUN: begin
                            n_x       = '0;
                            n_cls_cnt = '0;
                            n_state   = S_INIT;
                        end
                        CMD_QUERY: begin
                            n_qok   = {1'b0, i_in.target_vertex} < vn;
                            n_state = S_QRY;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out_idx   = '0;
                            n_out_tot   = r_cls_cnt;
                            n_out_err   = 1'b0;
                        end
                    endcase
                end
            end
            S_QRY: begin
                n_out_valid = 1'b1;
                n_out_idx   = r_qok ? r_cls_rd : '0;
                n_out_tot   = r_cls_cnt;
                n_out_err   = 1'b0;
                n_state     = S_IDLE;
            end
            // clearing pass over the active vertices
            S_INIT: begin
                vinfo_we = 1'b1;
                if (r_x == vn - CW'(1)) begin
                    n_x     = '0;
                    n_state = S_ROOT;
                end else begin
                    n_x = r_x + CW'(1);
                end
            end
            S_ROOT: begin
                if (r_x == vn) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = '0;
                    n_out_tot   = r_cls_cnt;
                    n_out_err   = 1'b0;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_ROOT2;
                end
            end
            S_ROOT2: begin
                if (r_vinfo_rd.done) begin
                    n_x     = r_x + CW'(1);
                    n_state = S_ROOT;
                end else begin
                    vinfo_we = 1'b1;
                    vinfo_wd = '{done: 1'b0, low: '0};
                    n_y      = r_x[VW-1:0];
                    n_y_done = 1'b0;
                    n_t      = CW'(1);
                    n_low_y  = '0;
                    n_cur    = r_vld_rd ? r_beg_rd : '0;
                    n_end    = r_vld_rd ? r_end_rd : '0;
                    n_state  = S_EDGE;
                end
            end
            S_EDGE: begin
                n_state = (r_cur < r_end) ? S_TGT : S_POP;
            end
            S_TGT: begin
                n_z = r_edge_rd;
                if ({1'b0, r_edge_rd} >= vn) begin
                    n_cur   = r_cur + ECW'(1);
                    n_state = S_EDGE;
                end else begin
                    vinfo_ra = r_edge_rd;
                    adj_ra   = r_edge_rd;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_EDGE;
                if (r_vinfo_rd.done) begin
                    n_cur = r_cur + ECW'(1);
                end else if (r_vinfo_rd.low == vn && r_t < vn) begin
                    // descend: park the current frame, z becomes top
                    stk_we   = 1'b1;
                    vinfo_we = 1'b1;
                    vinfo_wa = r_z;
                    vinfo_wd = '{done: 1'b0, low: r_t};
                    n_y      = r_z;
                    n_y_done = 1'b0;
                    n_low_y  = r_t;
                    n_t      = r_t + CW'(1);
                    n_cur    = r_vld_rd ? r_beg_rd : '0;
                    n_end    = r_vld_rd ? r_end_rd : '0;
                end else begin
                    if (r_low_y > r_vinfo_rd.low) begin
                        n_low_y  = r_vinfo_rd.low;
                        vinfo_we = 1'b1;
                        vinfo_wa = r_y;
                        vinfo_wd = '{done: r_y_done, low: r_vinfo_rd.low};
                    end
                    n_cur = r_cur + ECW'(1);
                end
            end
            S_POP: begin
                if (r_low_y == r_t - CW'(1)) begin
                    // root found: start the class sweep
                    vinfo_we = 1'b1;
                    vinfo_wa = r_y;
                    vinfo_wd = '{done: 1'b1, low: r_low_y};
                    cls_we   = 1'b1;
                    cls_wa   = r_y;
                    q_we     = 1'b1;
                    q_wa     = '0;
                    q_wd     = r_y;
                    n_head   = '0;
                    n_tail   = CW'(1);
                    n_state  = S_SW_HEAD;
                end else if (r_t == CW'(1)) begin
                    n_t     = '0;
                    n_x     = r_x + CW'(1);
                    n_state = S_ROOT;
                end else begin
                    n_prop  = 1'b1;
                    n_t     = r_t - CW'(1);
                    n_state = S_RESUME0;
                end
            end
            S_RESUME0: begin
                n_state = S_RES1;
            end
            S_RES1: begin
                vinfo_ra = r_stk_rd.vtx;
                adj_ra   = r_stk_rd.vtx;
                n_state  = S_RES2;
            end
            S_RES2: begin
                n_y      = r_stk_rd.vtx;
                n_y_done = r_vinfo_rd.done;
                n_cur    = r_stk_rd.cur;
                n_end    = r_vld_rd ? r_end_rd : '0;
                if (r_prop && r_low_y < r_vinfo_rd.low) begin
                    n_low_y  = r_low_y;
                    vinfo_we = 1'b1;
                    vinfo_wa = r_stk_rd.vtx;
                    vinfo_wd = '{done: r_vinfo_rd.done, low: r_low_y};
                end else begin
                    n_low_y = r_vinfo_rd.low;
                end
                n_state = S_EDGE;
            end
            S_SW_HEAD: begin
                if (r_head < r_tail) begin
                    n_head  = r_head + CW'(1);
                    n_state = S_SW_Q;
                end else begin
                    n_cls_cnt = r_cls_cnt + CW'(1);
                    n_t       = r_t - CW'(1);
                    if (r_t == CW'(1)) begin
                        n_x     = r_x + CW'(1);
                        n_state = S_ROOT;
                    end else begin
                        n_prop  = 1'b0;
                        n_state = S_RESUME0;
                    end
                end
            end
            S_SW_Q: begin
                adj_ra  = r_q_rd;
                n_state = S_SW_A;
            end
            S_SW_A: begin
                n_cur   = r_vld_rd ? r_beg_rd : '0;
                n_end   = r_vld_rd ? r_end_rd : '0;
                n_state = S_SW_E;
            end
            S_SW_E: begin
                n_state = (r_cur < r_end) ? S_SW_T : S_SW_HEAD;
            end
            S_SW_T: begin
                n_z = r_edge_rd;
                if ({1'b0, r_edge_rd} >= vn) begin
                    n_cur   = r_cur + ECW'(1);
                    n_state = S_SW_E;
                end else begin
                    vinfo_ra = r_edge_rd;
                    n_state  = S_SW_D;
                end
            end
            S_SW_D: begin
                if (!r_vinfo_rd.done) begin
                    vinfo_we = 1'b1;
                    vinfo_wa = r_z;
                    vinfo_wd = '{done: 1'b1, low: r_vinfo_rd.low};
                    cls_we   = 1'b1;
                    if (r_tail < vn) begin
                        q_we   = 1'b1;
                        n_tail = r_tail + CW'(1);
                    end
                end
                n_cur   = r_cur + ECW'(1);
                n_state = S_SW_E;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vcount    <= CW'(1);
            r_total     <= '0;
            r_any       <= 1'b0;
            r_adj_vld   <= '0;
            r_cls_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_wr_en) begin
                r_vcount <= i_cfg_wr_data;
            end
            r_total     <= n_total;
            r_any       <= n_any;
            r_adj_vld   <= n_adj_vld;
            r_cls_cnt   <= n_cls_cnt;
            r_out_valid <= n_out_valid;
        end
        r_last_src <= n_last_src;
        r_x        <= n_x;
        r_y        <= n_y;
        r_y_done   <= n_y_done;
        r_z        <= n_z;
        r_t        <= n_t;
        r_low_y    <= n_low_y;
        r_cur      <= n_cur;
        r_end      <= n_end;
        r_head     <= n_head;
        r_tail     <= n_tail;
        r_prop     <= n_prop;
        r_qok      <= n_qok;
        r_out_idx  <= n_out_idx;
        r_out_tot  <= n_out_tot;
        r_out_err  <= n_out_err;
    end

    // synchronous memories, registered read
    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            edge_mem[edge_wa] <= edge_wd;
        end
        r_edge_rd <= edge_mem[edge_ra];
    end

    always_ff @(posedge i_clk) begin
        if (beg_we) begin
            beg_mem[adj_wa] <= beg_wd;
        end
        if (end_we) begin
            end_mem[adj_wa] <= end_wd;
        end
        r_beg_rd <= beg_mem[adj_ra];
        r_end_rd <= end_mem[adj_ra];
        r_vld_rd <= r_adj_vld[adj_ra];
    end

    always_ff @(posedge i_clk) begin
        if (vinfo_we) begin
            vinfo_mem[vinfo_wa] <= vinfo_wd;
        end
        r_vinfo_rd <= vinfo_mem[vinfo_ra];
    end

    always_ff @(posedge i_clk) begin
        if (cls_we) begin
            cls_mem[cls_wa] <= cls_wd;
        end
        r_cls_rd <= cls_mem[cls_ra];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stk_mem[stk_wa] <= stk_wd;
        end
        r_stk_rd <= stk_mem[stk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            q_mem[q_wa] <= q_wd;
        end
        r_q_rd <= q_mem[q_ra];
    end

    // checks
    a_depth_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC) |-> ((r_t != '0) && (r_t <= vn)))
        else $error("walk depth out of range");

    a_add_grows_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in.command == CMD_ADD) && !add_err)
        |=> (r_total == $past(r_total) + ECW'(1)))
        else $error("accepted edge not stored");

    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (r_state == S_IDLE))
        else $error("ready outside idle");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SW_D) |-> ((r_tail <= vn) && (r_head <= r_tail)))
        else $error("sweep queue overrun");

endmodule
